@@ src/itr_pkg.sv @@
// Shared types and constants for the ISO-TP receive reassembler.
// No dependencies; the interfaces, the decoder, the top, the checker and the testbench import it.
package itr_pkg;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_code_t;

    typedef enum logic [1:0] {
        RX_IDLE      = 2'd0,
        RX_RECEIVING = 2'd1,
        RX_COMPLETE  = 2'd2,
        RX_ERROR     = 2'd3
    } rx_status_t;

    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    localparam logic [2:0]  SF_MAX_BYTES = 3'd7;
    localparam logic [2:0]  FF_BYTES     = 3'd6;
    localparam logic [2:0]  CF_MAX_BYTES = 3'd7;
    localparam logic [10:0] FC_ID_OFFSET = 11'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] can_id;
        logic [7:0]  frame_byte0;
        logic [7:0]  frame_byte1;
        logic [7:0]  frame_byte2;
        logic [7:0]  frame_byte3;
        logic [7:0]  frame_byte4;
        logic [7:0]  frame_byte5;
        logic [7:0]  frame_byte6;
        logic [7:0]  frame_byte7;
        logic [7:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] message_length;
        logic [11:0] bytes_received;
        logic        flow_control_valid;
        logic [10:0] flow_control_id;
        logic [7:0]  read_byte;
    } out_item_t;

    // Reassembly context held between frames.
    typedef struct packed {
        rx_status_t  rx_state;
        logic [11:0] expected_length;
        logic [11:0] stored_count;
        logic [3:0]  next_sequence;
    } ctx_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_READ,
        ACT_CLEAR
    } action_t;

    // Work plan produced by the frame decoder for one transfer.
    typedef struct packed {
        action_t     action;
        logic [11:0] wr_base;
        logic [2:0]  wr_count;
        logic [2:0]  wr_first;
        ctx_t        ctx_next;
        out_item_t   result;
    } plan_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } seq_state_t;

endpackage

@@ src/itr_if.sv @@
// Valid/ready channel interfaces for frame input and result output.
// Depends on itr_pkg for the payload structs.
interface itr_frame_if import itr_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface itr_result_if import itr_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/itr_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module itr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ src/itr_frame_decode.sv @@
// Frame decoder: turns one input transfer and the current reassembly context
// into the next context, the store access plan and the result. Uses itr_pkg.
module itr_frame_decode import itr_pkg::*; #(
    parameter int PAYLOAD_BYTES = 256
) (
    input  in_item_t item,
    input  ctx_t     ctx,
    output plan_t    plan
);

    localparam logic [12:0] STORE_SIZE = 13'(PAYLOAD_BYTES);

    logic [3:0]  ftype;
    logic [3:0]  low;
    logic [2:0]  sf_len;
    logic [11:0] ff_len;
    logic [11:0] left;
    logic [2:0]  cf_len;
    logic [11:0] cf_stored;

    assign ftype = item.frame_byte0[7:4];
    assign low   = item.frame_byte0[3:0];
    assign sf_len = (low > 4'(SF_MAX_BYTES)) ? SF_MAX_BYTES : low[2:0];
    assign ff_len = {low, item.frame_byte1};
    // Remaining length saturates at zero so the store is never overrun.
    assign left = (ctx.expected_length > ctx.stored_count) ?
                  (ctx.expected_length - ctx.stored_count) : 12'd0;
    assign cf_len = (left > 12'(CF_MAX_BYTES)) ? CF_MAX_BYTES : left[2:0];
    assign cf_stored = ctx.stored_count + 12'(cf_len);

    always_comb
    begin
        plan = '0;
        plan.action   = ACT_NONE;
        plan.ctx_next = ctx;
        plan.wr_first = 3'd1;

        unique case (op_code_t'(item.op))
            OP_CLEAR:
            begin
                plan.action   = ACT_CLEAR;
                plan.ctx_next = '0;
            end
            OP_READ:
            begin
                if ({5'd0, item.read_index} < STORE_SIZE)
                begin
                    plan.action = ACT_READ;
                end
            end
            OP_FRAME:
            begin
                if (ftype == FT_SINGLE)
                begin
                    plan.ctx_next.expected_length = 12'(sf_len);
                    plan.ctx_next.stored_count    = 12'(sf_len);
                    plan.ctx_next.rx_state        = RX_COMPLETE;
                    plan.wr_count                 = sf_len;
                    plan.action = (sf_len != 3'd0) ? ACT_WRITE : ACT_NONE;
                end
                else if (ftype == FT_FIRST)
                begin
                    plan.ctx_next.expected_length = ff_len;
                    if ({1'b0, ff_len} > STORE_SIZE)
                    begin
                        plan.ctx_next.rx_state = RX_ERROR;
                    end
                    else
                    begin
                        plan.ctx_next.stored_count  = 12'(FF_BYTES);
                        plan.ctx_next.next_sequence = 4'd1;
                        plan.ctx_next.rx_state      = RX_RECEIVING;
                        plan.action   = ACT_WRITE;
                        plan.wr_count = FF_BYTES;
                        plan.wr_first = 3'd2;
                        plan.result.flow_control_valid = 1'b1;
                        plan.result.flow_control_id    = item.can_id - FC_ID_OFFSET;
                    end
                end
                else if (ftype == FT_CONSEC && ctx.rx_state == RX_RECEIVING)
                begin
                    if (low != ctx.next_sequence)
                    begin
                        plan.ctx_next.rx_state = RX_ERROR;
                    end
                    else
                    begin
                        plan.ctx_next.stored_count  = cf_stored;
                        plan.ctx_next.next_sequence = ctx.next_sequence + 4'd1;
                        if (cf_stored >= ctx.expected_length)
                        begin
                            plan.ctx_next.rx_state = RX_COMPLETE;
                        end
                        plan.wr_base  = ctx.stored_count;
                        plan.wr_count = cf_len;
                        plan.action   = (cf_len != 3'd0) ? ACT_WRITE : ACT_NONE;
                    end
                end
            end
            OP_NOP:
            begin
                plan.action = ACT_NONE;
            end
        endcase

        plan.result.status         = plan.ctx_next.rx_state;
        plan.result.message_length = plan.ctx_next.expected_length;
        plan.result.bytes_received = plan.ctx_next.stored_count;
    end

endmodule

@@ src/isotp_receive_reassembler.sv @@
// Top level of the ISO-TP receive reassembler: sequencer, context registers
// and payload store. Uses itr_pkg, itr_if, itr_ram and itr_frame_decode.
//
// The block takes one CAN frame, clear or read request per transfer on the
// frame_in channel and returns exactly one result per request on result_out.
// A frame updates the reassembly context (state, announced length, bytes
// stored, sequence number) and writes its payload bytes into a single-port
// store of PAYLOAD_BYTES bytes, one byte per cycle. A first frame that fits
// the store raises flow_control_valid in its result, with the id set to the
// frame's id minus 8.
//
// Steps per request, from acceptance to the result being presented: a
// frame passes through the exec state, the write state once for each byte
// it stores (at most 7) and the done state; the single write port of the
// store takes its bytes one per cycle. A read passes through exec, read,
// read-wait and done, through the store's registered read. A clear passes
// through exec, the zeroing pass, which zeroes the store one entry per
// cycle, and done. One request is worked on at a time; the sequencer is
// back in idle at the edge that loads the result.
//
// After reset the same zeroing pass runs over the whole store before the
// first transfer is accepted. Results sit in an output register; while the
// receiver stalls, one further request may be accepted and worked on, and it
// then waits until the output register is free.
module isotp_receive_reassembler import itr_pkg::*; #(
    parameter int PAYLOAD_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    itr_frame_if.sink           frame_in,
    itr_result_if.source        result_out
);

    localparam int          AW         = $clog2(PAYLOAD_BYTES);
    localparam logic [12:0] STORE_SIZE = 13'(PAYLOAD_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_BYTES - 1);

    seq_state_t    state_reg, state_next;
    in_item_t      item_reg;
    ctx_t          ctx_reg, ctx_next;
    plan_t         plan_reg;
    plan_t         plan;
    out_item_t     res_reg, res_next;
    logic          res_pend_reg, res_pend_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;
    logic [2:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic [7:0]    frame_bytes [8];
    logic [11:0]   wr_pos;
    logic [2:0]    wr_src;
    logic [12:0]   rd_pos;
    logic          wr_last;
    logic          clr_last;
    logic          out_free;

    itr_frame_decode #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_decode (
        .item(item_reg),
        .ctx (ctx_reg),
        .plan(plan)
    );

    itr_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .re   (ram_re),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign frame_bytes[0] = item_reg.frame_byte0;
    assign frame_bytes[1] = item_reg.frame_byte1;
    assign frame_bytes[2] = item_reg.frame_byte2;
    assign frame_bytes[3] = item_reg.frame_byte3;
    assign frame_bytes[4] = item_reg.frame_byte4;
    assign frame_bytes[5] = item_reg.frame_byte5;
    assign frame_bytes[6] = item_reg.frame_byte6;
    assign frame_bytes[7] = item_reg.frame_byte7;

    // Byte k of a frame write goes to position base + k and comes from
    // frame byte first + k.
    assign wr_pos   = plan_reg.wr_base + {9'd0, wr_idx_reg};
    assign wr_src   = plan_reg.wr_first + wr_idx_reg;
    assign rd_pos   = {5'd0, item_reg.read_index};
    assign wr_last  = (wr_idx_reg == plan_reg.wr_count - 3'd1);
    assign clr_last = (clr_cnt_reg == LAST_ADDR);
    assign out_free = !out_valid_reg || result_out.ready;

    assign frame_in.ready   = (state_reg == ST_IDLE);
    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = res_pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (frame_in.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (plan.action)
                    ACT_CLEAR: state_next = ST_CLEAR;
                    ACT_WRITE: state_next = ST_WRITE;
                    ACT_READ:  state_next = ST_READ;
                    ACT_NONE:  state_next = ST_DONE;
                endcase
            end
            ST_WRITE:
            begin
                if (wr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store access, counters, context and result registers.
    always_comb
    begin
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = clr_cnt_reg;
        ram_wdata      = 8'd0;
        ctx_next       = ctx_reg;
        res_next       = res_reg;
        res_pend_next  = res_pend_reg;
        wr_idx_next    = wr_idx_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !result_out.ready;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_EXEC:
            begin
                ctx_next      = plan.ctx_next;
                res_next      = plan.result;
                res_pend_next = 1'b1;
                wr_idx_next   = 3'd0;
                clr_cnt_next  = '0;
            end
            ST_WRITE:
            begin
                ram_we      = ({1'b0, wr_pos} < STORE_SIZE);
                ram_addr    = wr_pos[AW-1:0];
                ram_wdata   = frame_bytes[wr_src];
                wr_idx_next = wr_idx_reg + 3'd1;
            end
            ST_READ:
            begin
                ram_re   = 1'b1;
                ram_addr = rd_pos[AW-1:0];
            end
            ST_READ_WAIT:
            begin
                res_next.read_byte = ram_rdata;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    res_pend_next  = 1'b0;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ctx_reg       <= '0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_idx_reg    <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            res_pend_reg  <= res_pend_next;
            out_valid_reg <= out_valid_next;
            wr_idx_reg    <= wr_idx_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            item_reg <= frame_in.data;
        end
        if (state_reg == ST_EXEC)
        begin
            plan_reg <= plan;
        end
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ src/itr_checker.sv @@
// Port-level checks for the ISO-TP receive reassembler, bound to its top.
// Uses itr_pkg; depends on isotp_receive_reassembler for the bind.
module itr_checker import itr_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("transfer accepted while previous request still in work");

    // Flow control is only requested by a first frame that starts reception.
    a_fc_receiving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.flow_control_valid |->
        out_data.status == RX_RECEIVING && out_data.bytes_received == 12'd6)
        else $error("flow control outside a started reception");

    a_fc_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.flow_control_valid |->
        out_data.flow_control_id == 11'd0)
        else $error("flow control id without flow control");

    // Idle is only reached through reset or clear, which zero the context.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == RX_IDLE |->
        out_data.message_length == 12'd0 && out_data.bytes_received == 12'd0)
        else $error("idle status with nonzero context");

endmodule

bind isotp_receive_reassembler itr_checker u_itr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (frame_in.valid),
    .in_ready (frame_in.ready),
    .out_valid(result_out.valid),
    .out_ready(result_out.ready),
    .out_data (result_out.data)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the ISO-TP receive reassembler.
// Depends on itr_pkg, itr_if and isotp_receive_reassembler. A local reassembly
// model predicts each result; a directed table runs first, then random traffic.
module tb_top import itr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES    = 256;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int HOLD_AFTER     = 300;   // input transfers before the long result stall
    localparam int HOLD_CYCLES    = 400;
    // A clear and the zeroing pass after reset each run over the whole
    // store. The long stall and the longest random gaps come on top of
    // that, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    // One row of stimulus. When typed is set, want is the result written into
    // the table by hand. Otherwise the result comes from the reassembly model.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    itr_frame_if  frame_ch ();
    itr_result_if result_ch ();

    isotp_receive_reassembler #(
        .PAYLOAD_BYTES (STORE_BYTES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_ch),
        .result_out (result_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Reassembly model: a copy of the context and of the payload store.
    // ------------------------------------------------------------------
    rx_status_t  ctx_state = RX_IDLE;
    logic [11:0] ctx_length = '0;
    logic [11:0] ctx_count = '0;
    logic [3:0]  ctx_seq = '0;
    logic [7:0]  store_image [STORE_BYTES];

    stim_row_t   stim_rows [$];
    out_item_t   awaited_results [$];
    int          row_on_bus;
    bit          stim_ready;
    bit          stimulus_done;
    bit          hold_active;
    bit          hold_done;
    int          frames_accepted;
    int          results_checked;
    int          mismatches;
    int          idle_cycles;
    int          messages_built;
    int          clears_built;

    // Applies one request to the model and returns the result it must cause.
    function automatic out_item_t reassemble_step(in_item_t it);
        out_item_t  res;
        logic [7:0] fb [8];
        logic [3:0] ftype;
        logic [3:0] low;
        int         n;
        int         left;

        res = '0;
        fb = '{it.frame_byte0, it.frame_byte1, it.frame_byte2, it.frame_byte3,
               it.frame_byte4, it.frame_byte5, it.frame_byte6, it.frame_byte7};
        ftype = fb[0][7:4];
        low = fb[0][3:0];
        case (it.op)
            OP_CLEAR:
            begin
                ctx_state = RX_IDLE;
                ctx_length = '0;
                ctx_count = '0;
                ctx_seq = '0;
                foreach (store_image[i])
                    store_image[i] = '0;
            end
            OP_READ:
            begin
                res.read_byte = store_image[it.read_index];
            end
            OP_FRAME:
            begin
                if (ftype == FT_SINGLE)
                begin
                    // Single frame: length above seven is clamped to seven.
                    n = (low > 4'd7) ? 7 : int'(low);
                    for (int i = 0; i < n; i++)
                        store_image[i] = fb[1 + i];
                    ctx_length = 12'(n);
                    ctx_count = 12'(n);
                    ctx_state = RX_COMPLETE;
                end
                else if (ftype == FT_FIRST)
                begin
                    ctx_length = {low, fb[1]};
                    if (ctx_length > STORE_BYTES)
                    begin
                        // Too long for the store: error, nothing stored.
                        ctx_state = RX_ERROR;
                    end
                    else
                    begin
                        for (int i = 0; i < 6; i++)
                            store_image[i] = fb[2 + i];
                        ctx_count = 12'd6;
                        ctx_seq = 4'd1;
                        ctx_state = RX_RECEIVING;
                        res.flow_control_valid = 1'b1;
                        res.flow_control_id = it.can_id - FC_ID_OFFSET;
                    end
                end
                else if (ftype == FT_CONSEC && ctx_state == RX_RECEIVING)
                begin
                    if (low != ctx_seq)
                    begin
                        ctx_state = RX_ERROR;
                    end
                    else
                    begin
                        // The remaining length never goes below zero.
                        left = (ctx_length > ctx_count) ?
                               int'(ctx_length) - int'(ctx_count) : 0;
                        n = (left > 7) ? 7 : left;
                        for (int i = 0; i < n; i++)
                            if (int'(ctx_count) + i < STORE_BYTES)
                                store_image[int'(ctx_count) + i] = fb[1 + i];
                        ctx_count = ctx_count + 12'(n);
                        ctx_seq = ctx_seq + 4'd1;
                        if (ctx_count >= ctx_length)
                            ctx_state = RX_COMPLETE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.status = ctx_state;
        res.message_length = ctx_length;
        res.bytes_received = ctx_count;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic in_item_t frm(op_code_t op, logic [10:0] id, logic [63:0] bytes,
                                     logic [7:0] idx);
        in_item_t it;

        it.op = op;
        it.can_id = id;
        it.frame_byte0 = bytes[63:56];
        it.frame_byte1 = bytes[55:48];
        it.frame_byte2 = bytes[47:40];
        it.frame_byte3 = bytes[39:32];
        it.frame_byte4 = bytes[31:24];
        it.frame_byte5 = bytes[23:16];
        it.frame_byte6 = bytes[15:8];
        it.frame_byte7 = bytes[7:0];
        it.read_index = idx;
        return it;
    endfunction

    function automatic out_item_t res(rx_status_t st, int len, int cnt, bit fcv, int fcid,
                                      int rb);
        out_item_t r;

        r.status = st;
        r.message_length = 12'(len);
        r.bytes_received = 12'(cnt);
        r.flow_control_valid = fcv;
        r.flow_control_id = 11'(fcid);
        r.read_byte = 8'(rb);
        return r;
    endfunction

    function automatic in_item_t rand_item(op_code_t op);
        logic [63:0] bytes;

        bytes = {$urandom, $urandom};
        return frm(op, 11'($urandom), bytes, 8'($urandom));
    endfunction

    task automatic add_item(in_item_t it);
        stim_row_t row;

        row.item = it;
        row.typed = 1'b0;
        row.want = '0;
        stim_rows.push_back(row);
    endtask

    // Idle length for either side: mostly short, now and then long.
    function automatic int pick_gap();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Control: build the stimulus, reset, wait for the end and report.
    // ------------------------------------------------------------------
    initial
    begin : run_control
        stim_row_t   directed_rows [25];
        in_item_t    it;
        int          pick;
        int          msg_len;
        int          cf_count;
        int          break_at;
        bit          broken;
        logic [3:0]  seq;

        rst_n = 1'b0;
        foreach (store_image[i])
            store_image[i] = '0;

        // Directed part. Results that are plain to see are typed in; the
        // rest are left to the model.
        directed_rows = '{
            // Read and no-op straight after reset: everything is zero.
            '{frm(OP_READ,  11'h000, 64'h0, 8'd0), 1'b1, res(RX_IDLE, 0, 0, 0, 0, 0)},
            '{frm(OP_NOP,   11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF), 1'b1,
              res(RX_IDLE, 0, 0, 0, 0, 0)},
            // Single frames with length zero, seven and fifteen (clamped).
            '{frm(OP_FRAME, 11'h100, 64'h00AA_AAAA_AAAA_AAAA, 8'd0), 1'b1,
              res(RX_COMPLETE, 0, 0, 0, 0, 0)},
            '{frm(OP_FRAME, 11'h100, 64'h0711_2233_4455_6677, 8'd0), 1'b1,
              res(RX_COMPLETE, 7, 7, 0, 0, 0)},
            '{frm(OP_READ,  11'h000, 64'h0, 8'd6), 1'b1, res(RX_COMPLETE, 7, 7, 0, 0, 8'h77)},
            '{frm(OP_FRAME, 11'h7FF, 64'h0FFF_FFFF_FFFF_FFFF, 8'd0), 1'b1,
              res(RX_COMPLETE, 7, 7, 0, 0, 0)},
            '{frm(OP_READ,  11'h000, 64'h0, 8'd255), 1'b1, res(RX_COMPLETE, 7, 7, 0, 0, 0)},
            // First frames too long for the store, just over and at the top.
            '{frm(OP_FRAME, 11'h123, 64'h1101_0102_0304_0506, 8'd0), 1'b1,
              res(RX_ERROR, 257, 7, 0, 0, 0)},
            '{frm(OP_FRAME, 11'h123, 64'h1FFF_0102_0304_0506, 8'd0), 1'b1,
              res(RX_ERROR, 4095, 7, 0, 0, 0)},
            // Consecutive frame while not receiving, and unknown frame types.
            '{frm(OP_FRAME, 11'h123, 64'h2101_0203_0405_0607, 8'd0), 1'b1,
              res(RX_ERROR, 4095, 7, 0, 0, 0)},
            '{frm(OP_FRAME, 11'h123, 64'h3F00_0000_0000_0000, 8'd0), 1'b1,
              res(RX_ERROR, 4095, 7, 0, 0, 0)},
            '{frm(OP_FRAME, 11'h123, 64'hF000_0000_0000_0000, 8'd0), 1'b1,
              res(RX_ERROR, 4095, 7, 0, 0, 0)},
            // Clear empties the context and the store.
            '{frm(OP_CLEAR, 11'h000, 64'h0, 8'd0), 1'b1, res(RX_IDLE, 0, 0, 0, 0, 0)},
            '{frm(OP_READ,  11'h000, 64'h0, 8'd0), 1'b1, res(RX_IDLE, 0, 0, 0, 0, 0)},
            // Longest first frame that fits; the id wraps below zero.
            '{frm(OP_FRAME, 11'h000, 64'h1100_A0A1_A2A3_A4A5, 8'd0), 1'b1,
              res(RX_RECEIVING, 256, 6, 1, 2040, 0)},
            // Out of sequence.
            '{frm(OP_FRAME, 11'h000, 64'h2201_0203_0405_0607, 8'd0), 1'b1,
              res(RX_ERROR, 256, 6, 0, 0, 0)},
            // First frame shorter than six bytes, then a frame that adds nothing.
            '{frm(OP_FRAME, 11'h7FF, 64'h1003_B0B1_B2B3_B4B5, 8'd0), 1'b1,
              res(RX_RECEIVING, 3, 6, 1, 2039, 0)},
            '{frm(OP_FRAME, 11'h7FF, 64'h21C0_C1C2_C3C4_C5C6, 8'd0), 1'b1,
              res(RX_COMPLETE, 3, 6, 0, 0, 0)},
            '{frm(OP_READ,  11'h000, 64'h0, 8'd5), 1'b0, '0},
            // A short message of three frames, read back and one frame too many.
            '{frm(OP_FRAME, 11'h123, 64'h1014_0001_0203_0405, 8'd0), 1'b0, '0},
            '{frm(OP_FRAME, 11'h123, 64'h2106_0708_090A_0B0C, 8'd0), 1'b0, '0},
            '{frm(OP_FRAME, 11'h123, 64'h220D_0E0F_1011_1213, 8'd0), 1'b0, '0},
            '{frm(OP_READ,  11'h000, 64'h0, 8'd19), 1'b0, '0},
            '{frm(OP_FRAME, 11'h123, 64'h2314_1516_1718_191A, 8'd0), 1'b0, '0},
            '{frm(OP_FRAME, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF), 1'b0, '0}
        };
        foreach (directed_rows[r])
            stim_rows.push_back(directed_rows[r]);

        // Random part: mostly complete messages with random content, mixed
        // with single frames, reads, clears, broken sequences and noise.
        while (stim_rows.size() < $size(directed_rows) + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, STORE_BYTES) :
                                                       $urandom_range(7, 48);
                it = rand_item(OP_FRAME);
                it.frame_byte0 = {FT_FIRST, 4'(msg_len >> 8)};
                it.frame_byte1 = 8'(msg_len);
                add_item(it);
                seq = 4'd1;
                cf_count = (msg_len <= 6) ? 1 : (msg_len - 6 + 6) / 7;
                broken = ($urandom_range(0, 19) == 0);
                break_at = $urandom_range(0, cf_count - 1);
                for (int c = 0; c < cf_count; c++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_item(rand_item(OP_READ));
                    it = rand_item(OP_FRAME);
                    if (broken && c == break_at)
                    begin
                        it.frame_byte0 = {FT_CONSEC, seq + 4'($urandom_range(1, 15))};
                        add_item(it);
                        break;
                    end
                    it.frame_byte0 = {FT_CONSEC, seq};
                    add_item(it);
                    seq = seq + 4'd1;
                end
                repeat ($urandom_range(1, 3))
                begin
                    it = rand_item(OP_READ);
                    if (msg_len > 0)
                        it.read_index = 8'($urandom_range(0, (msg_len > 255) ? 255 :
                                                             msg_len - 1));
                    add_item(it);
                end
                messages_built++;
            end
            else if (pick < 72)
            begin
                it = rand_item(OP_FRAME);
                it.frame_byte0 = {FT_SINGLE, 4'($urandom_range(0, 15))};
                add_item(it);
            end
            else if (pick < 80)
            begin
                add_item(rand_item(OP_READ));
            end
            else if (pick < 84)
            begin
                it = rand_item(OP_FRAME);
                if ($urandom_range(0, 1) == 0)
                    it.frame_byte0 = {4'($urandom_range(3, 15)), 4'($urandom)};
                else
                    it.frame_byte0 = {FT_CONSEC, 4'($urandom)};
                add_item(it);
            end
            else if (pick < 88)
            begin
                msg_len = $urandom_range(STORE_BYTES + 1, 4095);
                it = rand_item(OP_FRAME);
                it.frame_byte0 = {FT_FIRST, 4'(msg_len >> 8)};
                it.frame_byte1 = 8'(msg_len);
                add_item(it);
            end
            else if (pick < 90)
            begin
                add_item(rand_item(OP_NOP));
            end
            else if (pick < 92)
            begin
                add_item(rand_item(OP_CLEAR));
                clears_built++;
            end
            else
            begin
                add_item(rand_item(op_code_t'($urandom_range(0, 3))));
            end
        end
        stim_ready = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every row has had its result checked, then give the
        // block time to show anything it should not send.
        while (!(stimulus_done && results_checked == stim_rows.size()))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transfers (%0d multi-frame messages, %0d clears), checked %0d results.",
                 frames_accepted, messages_built, clears_built, results_checked);
        $display("Result channel was held off once for %0d cycles; %0d mismatches seen.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame source: walks the stimulus rows with random gaps. During the
    // long result stall it offers back to back so the block fills up.
    // ------------------------------------------------------------------
    initial
    begin : frame_source
        int gap;

        frame_ch.valid <= 1'b0;
        frame_ch.data  <= '0;
        row_on_bus     <= 0;
        wait (stim_ready && rst_n === 1'b1);
        @(posedge clk);
        foreach (stim_rows[k])
        begin
            gap = hold_active ? 0 : pick_gap();
            if (gap > 0)
            begin
                frame_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            frame_ch.valid <= 1'b1;
            frame_ch.data  <= stim_rows[k].item;
            row_on_bus     <= k;
            @(posedge clk);
            while (!frame_ch.ready)
                @(posedge clk);
        end
        frame_ch.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Result sink: random ready pattern with some long steady stretches,
    // plus one long hold-off once enough transfers have gone in.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int on_len;
        int off_len;

        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            on_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                   $urandom_range(1, 16);
            result_ch.ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            if (!hold_done && frames_accepted >= HOLD_AFTER)
            begin
                hold_active = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                off_len = pick_gap();
                if (off_len > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (off_len) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted input transfer queues its expected result;
    // every accepted output transfer is checked against the oldest one.
    // Signals are read at the clock edge before any update of that edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : transfer_monitor
        out_item_t predicted;
        out_item_t want;
        out_item_t got;
        bit        moved;

        if (rst_n === 1'b1)
        begin
            moved = 1'b0;
            if (frame_ch.valid && frame_ch.ready)
            begin
                predicted = reassemble_step(frame_ch.data);
                if (stim_rows[row_on_bus].typed)
                    awaited_results.push_back(stim_rows[row_on_bus].want);
                else
                    awaited_results.push_back(predicted);
                frames_accepted++;
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                moved = 1'b1;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ns: result transfer with none awaited, actual %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("message_length", want.message_length, got.message_length);
                    check_field("bytes_received", want.bytes_received, got.bytes_received);
                    check_field("flow_control_valid", want.flow_control_valid,
                                got.flow_control_valid);
                    check_field("flow_control_id", want.flow_control_id, got.flow_control_id);
                    check_field("read_byte", want.read_byte, got.read_byte);
                    results_checked++;
                end
            end
            // Watchdog: a stretch with no transfer on either side is a hang.
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d results still awaited",
                         $time, idle_cycles, awaited_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
src/itr_pkg.sv
src/itr_if.sv
src/itr_ram.sv
src/itr_frame_decode.sv
src/isotp_receive_reassembler.sv
src/itr_checker.sv
tb/tb_top.sv
